### rtl/core/hsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_pkg
// Character codes, field numbers and the control bundle shared by the
// housekeeping sentence parser modules.
// ----------------------------------------------------------------------------
package hsp_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_D      = 8'h44;

    localparam int unsigned POS_BITS   = 7;
    localparam int unsigned FIELD_BITS = 4;

    localparam logic [FIELD_BITS-1:0] FIELD_CAP     = 4'd10;
    localparam logic [FIELD_BITS-1:0] FIELD_TEMP    = 4'd1;
    localparam logic [FIELD_BITS-1:0] FIELD_VOLTAGE = 4'd2;
    localparam logic [FIELD_BITS-1:0] FIELD_COUNT   = 4'd3;

    // first position after the newline of the shortest line that can match
    localparam logic [POS_BITS-1:0] MIN_MATCH_POS = 7'd7;

    localparam logic [POS_BITS-1:0] HDR_FIRST = 7'd1;
    localparam logic [POS_BITS-1:0] HDR_LAST  = 7'd5;

    typedef struct packed {
        logic       line_start;  // byte stored at position 0
        logic [2:0] dig_en;      // digit for temperature / voltage / count
        logic [3:0] digit;
        logic       eol;         // newline, a result is produced
        logic       matched;
    } hsp_ctrl_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd1:    c = CH_T;
            3'd2:    c = CH_C;
            3'd3:    c = CH_H;
            3'd4:    c = CH_K;
            3'd5:    c = CH_D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/core/hsp_digit_acc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_digit_acc
// Saturating decimal accumulator: acc = min(acc * 10 + digit, 2^N - 1).
// ----------------------------------------------------------------------------
module hsp_digit_acc #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  clear,
    input  wire logic                  load,
    input  wire logic [3:0]            digit,
    output logic      [VALUE_BITS-1:0] acc
);

    localparam int SUM_BITS = VALUE_BITS + 4;
    localparam logic [SUM_BITS-1:0] SAT = {4'b0000, {VALUE_BITS{1'b1}}};

    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic [VALUE_BITS-1:0] base;
    logic [SUM_BITS-1:0]   wide;
    logic [SUM_BITS-1:0]   sum;

    always_comb
    begin
        base = clear ? '0 : acc_reg;
        wide = {4'b0000, base};
        sum  = (wide << 3) + (wide << 1) + {{(SUM_BITS-4){1'b0}}, digit};
        if (load)
        begin
            acc_next = (sum > SAT) ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
        end
        else
        begin
            acc_next = base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (clear || load)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

### rtl/core/hsp_line_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_line_ctrl
// Line position, header check and comma field counter. Decodes each byte
// into accumulator enables and the end-of-line result flags.
// ----------------------------------------------------------------------------
module hsp_line_ctrl
    import hsp_pkg::*;
#(
    parameter int MAX_LINE = 80
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       go,
    input  wire logic [7:0] rx_char,
    output hsp_ctrl_t       ctrl
);

    localparam logic [POS_BITS-1:0] POS_LIMIT = POS_BITS'(MAX_LINE);

    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic                  hg_reg, hg_next;
    logic [FIELD_BITS-1:0] fn_reg, fn_next;

    logic [POS_BITS-1:0]   p;
    logic [POS_BITS-1:0]   pos_step;
    logic                  take;
    logic                  line_start;
    logic                  hg_base;
    logic                  mismatch;
    logic [FIELD_BITS-1:0] fn_base;
    logic [FIELD_BITS-1:0] fn_new;
    logic                  is_digit;
    logic [7:0]            digit_wide;

    always_comb
    begin
        p          = ((rx_char == CH_DOLLAR) || (pos_reg >= POS_LIMIT)) ? '0 : pos_reg;
        take       = (rx_char != CH_CR);
        line_start = take && (p == '0);
        hg_base    = line_start ? 1'b1 : hg_reg;
        mismatch   = (p >= HDR_FIRST) && (p <= HDR_LAST) && (rx_char != hdr_char(p[2:0]));
        fn_base    = line_start ? '0 : fn_reg;
        is_digit   = (rx_char >= CH_ZERO) && (rx_char <= CH_NINE);
        digit_wide = rx_char - CH_ZERO;

        fn_new      = fn_base;
        ctrl.dig_en = 3'b000;
        if (fn_base < FIELD_CAP)
        begin
            if (rx_char == CH_COMMA)
            begin
                fn_new = fn_base + 1'b1;
            end
            else if (is_digit)
            begin
                ctrl.dig_en[0] = (fn_base == FIELD_TEMP);
                ctrl.dig_en[1] = (fn_base == FIELD_VOLTAGE);
                ctrl.dig_en[2] = (fn_base == FIELD_COUNT);
            end
            else if ((rx_char == CH_STAR) && (fn_base == FIELD_COUNT))
            begin
                fn_new = fn_base + 1'b1;
            end
        end

        pos_step = take ? (p + 1'b1) : p;
        hg_next  = take ? (hg_base && !mismatch) : hg_reg;
        fn_next  = take ? fn_new : fn_reg;

        ctrl.line_start = line_start;
        ctrl.digit      = digit_wide[3:0];
        ctrl.eol        = (rx_char == CH_LF);
        ctrl.matched    = hg_next && (pos_step >= MIN_MATCH_POS);
        pos_next        = ctrl.eol ? '0 : pos_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hg_reg  <= 1'b0;
            fn_reg  <= '0;
        end
        else if (go)
        begin
            pos_reg <= pos_next;
            hg_reg  <= hg_next;
            fn_reg  <= fn_next;
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("line position beyond limit");

    a_field_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fn_reg <= FIELD_CAP)
        else $error("field number beyond cap");

    a_eol_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        go && ctrl.eol |=> pos_reg == '0)
        else $error("line position not rewound after newline");

endmodule
`default_nettype wire

### rtl/core/housekeeping_sentence_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// housekeeping_sentence_parser_top
// Parses "$TCHKD,<temp>,<voltage>,<count>*..." lines byte by byte and
// reports the committed values on each newline.
// ----------------------------------------------------------------------------
// Takes one byte per clock. Each byte lands in an input register and is
// decoded in the following cycle against the line state; a newline loads
// the result register when it is processed, which a stall can delay. Only
// a newline that meets an untaken result stalls the input side; every
// other byte flows at one per cycle.
module housekeeping_sentence_parser_top
    import hsp_pkg::*;
#(
    parameter int MAX_LINE   = 80,
    parameter int VALUE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             header_matched,
    output logic [15:0]      temperature,
    output logic [15:0]      supply_voltage,
    output logic [15:0]      message_count
);

    localparam int WIDE = (VALUE_BITS > 16) ? VALUE_BITS : 16;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  matched_reg;
    logic [15:0]           temp_out_reg, volt_out_reg, cnt_out_reg;
    logic [VALUE_BITS-1:0] temp_cm_reg, volt_cm_reg, cnt_cm_reg;
    logic [VALUE_BITS-1:0] temp_acc, volt_acc, cnt_acc;
    logic [VALUE_BITS-1:0] temp_sel, volt_sel, cnt_sel;
    logic [WIDE-1:0]       temp_ext, volt_ext, cnt_ext;
    logic                  out_free;
    logic                  proc_go;
    logic                  emit;
    hsp_ctrl_t             ctrl;

    assign out_free = !out_valid_reg || out_ready;
    assign proc_go  = in_valid_reg && (!ctrl.eol || out_free);
    assign emit     = proc_go && ctrl.eol;
    assign in_ready = !in_valid_reg || proc_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    hsp_line_ctrl #(
        .MAX_LINE (MAX_LINE)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (proc_go),
        .rx_char (in_byte_reg),
        .ctrl    (ctrl)
    );

    hsp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_temp (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (proc_go && ctrl.line_start),
        .load  (proc_go && ctrl.dig_en[0]),
        .digit (ctrl.digit),
        .acc   (temp_acc)
    );

    hsp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_volt (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (proc_go && ctrl.line_start),
        .load  (proc_go && ctrl.dig_en[1]),
        .digit (ctrl.digit),
        .acc   (volt_acc)
    );

    hsp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_cnt (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (proc_go && ctrl.line_start),
        .load  (proc_go && ctrl.dig_en[2]),
        .digit (ctrl.digit),
        .acc   (cnt_acc)
    );

    // a matching line is never at line start, so the accumulators are settled
    always_comb
    begin
        temp_sel = ctrl.matched ? temp_acc : temp_cm_reg;
        volt_sel = ctrl.matched ? volt_acc : volt_cm_reg;
        cnt_sel  = ctrl.matched ? cnt_acc  : cnt_cm_reg;
        temp_ext = WIDE'(temp_sel);
        volt_ext = WIDE'(volt_sel);
        cnt_ext  = WIDE'(cnt_sel);
        out_valid_next = emit ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            temp_cm_reg   <= '0;
            volt_cm_reg   <= '0;
            cnt_cm_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit && ctrl.matched)
            begin
                temp_cm_reg <= temp_acc;
                volt_cm_reg <= volt_acc;
                cnt_cm_reg  <= cnt_acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            matched_reg  <= ctrl.matched;
            temp_out_reg <= temp_ext[15:0];
            volt_out_reg <= volt_ext[15:0];
            cnt_out_reg  <= cnt_ext[15:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign header_matched = matched_reg;
    assign temperature    = temp_out_reg;
    assign supply_voltage = volt_out_reg;
    assign message_count  = cnt_out_reg;

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("newline did not raise a result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && ctrl.eol && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked newline");

    a_commit_match: assert property (@(posedge clk) disable iff (!rst_n)
        emit && ctrl.matched |=> temp_cm_reg == $past(temp_acc)
                                 && cnt_cm_reg == $past(cnt_acc))
        else $error("matched line not committed");

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the housekeeping sentence parser. Byte streams of
// good, damaged, short, long and noisy lines go in with random gaps, and a
// scoreboard predicts the readout for every newline and checks it field by
// field as it comes out under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import hsp_pkg::*;

    localparam int          LINE_LIMIT = 80;
    localparam int          ACC_BITS   = 16;
    localparam int unsigned ACC_MAX    = (1 << ACC_BITS) - 1;
    localparam int          RX_TARGET  = 1300;

    typedef struct packed {
        logic        header_matched;
        logic [15:0] temperature;
        logic [15:0] supply_voltage;
        logic [15:0] message_count;
    } readout_t;

    class sentence_scoreboard;
        logic [POS_BITS-1:0]   line_pos;
        logic                  hdr_ok;
        logic [FIELD_BITS-1:0] field_no;
        int unsigned           temp_acc;
        int unsigned           volt_acc;
        int unsigned           count_acc;
        logic [15:0]           held_temp;
        logic [15:0]           held_volt;
        logic [15:0]           held_count;
        logic [7:0]            hdr_text[1:5];
        readout_t              pending_readouts[$];
        int unsigned           lines_seen;
        int unsigned           lines_matched;
        int unsigned           errors;

        function new();
            line_pos      = '0;
            hdr_ok        = 1'b0;
            field_no      = '0;
            temp_acc      = 0;
            volt_acc      = 0;
            count_acc     = 0;
            held_temp     = '0;
            held_volt     = '0;
            held_count    = '0;
            hdr_text      = '{CH_T, CH_C, CH_H, CH_K, CH_D};
            lines_seen    = 0;
            lines_matched = 0;
            errors        = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned add_digit(input int unsigned acc, input logic [7:0] b);
            int unsigned v;
            v = acc * 10 + (b - CH_ZERO);
            return (v > ACC_MAX) ? ACC_MAX : v;
        endfunction

        // one stored character: header compare, comma count, digit accumulation
        function void store_char(input logic [7:0] b);
            if (line_pos == 0)
            begin
                hdr_ok    = 1'b1;
                field_no  = '0;
                temp_acc  = 0;
                volt_acc  = 0;
                count_acc = 0;
            end
            if (line_pos >= HDR_FIRST && line_pos <= HDR_LAST && b != hdr_text[line_pos])
                hdr_ok = 1'b0;
            if (field_no < FIELD_CAP)
            begin
                if (b == CH_COMMA)
                    field_no++;
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    if (field_no == FIELD_TEMP)
                        temp_acc = add_digit(temp_acc, b);
                    else if (field_no == FIELD_VOLTAGE)
                        volt_acc = add_digit(volt_acc, b);
                    else if (field_no == FIELD_COUNT)
                        count_acc = add_digit(count_acc, b);
                end
                else if (b == CH_STAR && field_no == FIELD_COUNT)
                    field_no++;
            end
            line_pos++;
        endfunction

        function void note_rx_byte(input logic [7:0] b);
            readout_t r;
            if (b == CH_DOLLAR || line_pos >= LINE_LIMIT)
                line_pos = '0;
            if (b != CH_CR)
                store_char(b);
            if (b == CH_LF)
            begin
                r.header_matched = hdr_ok && (line_pos >= MIN_MATCH_POS);
                if (r.header_matched)
                begin
                    held_temp  = temp_acc[15:0];
                    held_volt  = volt_acc[15:0];
                    held_count = count_acc[15:0];
                    lines_matched++;
                end
                r.temperature    = held_temp;
                r.supply_voltage = held_volt;
                r.message_count  = held_count;
                pending_readouts.push_back(r);
                lines_seen++;
                line_pos = '0;
            end
        endfunction

        task check_readout(input logic hm, input logic [15:0] t, input logic [15:0] v,
                           input logic [15:0] c);
            readout_t want;
            if (pending_readouts.size() == 0)
            begin
                report($sformatf("result with nothing pending: %0b %0d %0d %0d", hm, t, v, c));
                return;
            end
            want = pending_readouts.pop_front();
            if (hm !== want.header_matched)
                report($sformatf("header_matched %0b, want %0b", hm, want.header_matched));
            if (t !== want.temperature)
                report($sformatf("temperature %0d, want %0d", t, want.temperature));
            if (v !== want.supply_voltage)
                report($sformatf("supply_voltage %0d, want %0d", v, want.supply_voltage));
            if (c !== want.message_count)
                report($sformatf("message_count %0d, want %0d", c, want.message_count));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        header_matched;
    logic [15:0] temperature;
    logic [15:0] supply_voltage;
    logic [15:0] message_count;

    sentence_scoreboard sb;
    logic [7:0]         tx_bytes[$];

    always #6 clk = ~clk;

    housekeeping_sentence_parser_top #(
        .MAX_LINE   (LINE_LIMIT),
        .VALUE_BITS (ACC_BITS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .header_matched (header_matched),
        .temperature    (temperature),
        .supply_voltage (supply_voltage),
        .message_count  (message_count)
    );

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endtask

    // printable, never a line restart
    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        return (c == CH_DOLLAR) ? 8'h23 : c;
    endfunction

    task automatic add_number();
        int ndig;
        string junk;
        junk = " *-.aZ";
        ndig = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom_range(6, 9);
        for (int i = 0; i < ndig; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                tx_bytes.push_back(junk[$urandom_range(0, junk.len() - 1)]);
            tx_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    task automatic add_sentence(input bit corrupt, input bit many_fields);
        string hdr;
        string hexd;
        logic [7:0] c;
        int bad;
        int nfields;
        hdr  = "TCHKD";
        hexd = "0123456789ABCDEF";
        bad  = $urandom_range(0, 4);
        // a line may also begin right after the previous newline, without '$'
        tx_bytes.push_back(($urandom_range(0, 6) == 0) ? filler_char() : CH_DOLLAR);
        for (int i = 0; i < 5; i++)
        begin
            c = hdr[i];
            if (corrupt && i == bad)
                c = c ^ (8'h01 << $urandom_range(0, 7));
            tx_bytes.push_back(c);
        end
        nfields = many_fields ? $urandom_range(10, 14) : 3;
        for (int f = 0; f < nfields; f++)
        begin
            tx_bytes.push_back(CH_COMMA);
            add_number();
        end
        if ($urandom_range(0, 9) < 7)
        begin
            tx_bytes.push_back(CH_STAR);
            tx_bytes.push_back(hexd[$urandom_range(0, 15)]);
            tx_bytes.push_back(hexd[$urandom_range(0, 15)]);
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            tx_bytes.push_back(CH_COMMA);
            add_number();
        end
        if ($urandom_range(0, 1) == 1)
            tx_bytes.push_back(CH_CR);
        tx_bytes.push_back(CH_LF);
    endtask

    task automatic add_line();
        int kind;
        int start;
        int target;
        string hdr;
        hdr  = "TCHKD";
        kind = $urandom_range(0, 99);
        if (kind < 55)
            add_sentence(1'b0, 1'b0);
        else if (kind < 65)
            add_sentence(1'b1, 1'b0);
        else if (kind < 73)
        begin
            // short line, possibly cut inside the header
            if ($urandom_range(0, 3) != 0)
                tx_bytes.push_back(CH_DOLLAR);
            target = $urandom_range(0, 5);
            for (int i = 0; i < target; i++)
                tx_bytes.push_back(hdr[i]);
            tx_bytes.push_back(CH_LF);
        end
        else if (kind < 79)
            add_sentence($urandom_range(0, 7) == 0, 1'b1);
        else if (kind < 85)
        begin
            // long line: either a carriage return exactly at the limit or a random length that may wrap
            start = tx_bytes.size();
            tx_bytes.push_back(CH_DOLLAR);
            add_text("TCHKD,");
            add_number();
            target = ($urandom_range(0, 1) == 1) ? LINE_LIMIT : $urandom_range(70, 120);
            while (tx_bytes.size() - start < target)
                tx_bytes.push_back(filler_char());
            if (target == LINE_LIMIT)
                tx_bytes.push_back(CH_CR);
            tx_bytes.push_back(CH_LF);
        end
        else if (kind < 90)
        begin
            // partial line, usually abandoned by a new '$'
            tx_bytes.push_back(CH_DOLLAR);
            target = $urandom_range(0, 5);
            for (int i = 0; i < target; i++)
                tx_bytes.push_back(hdr[i]);
            add_number();
            add_sentence(1'b0, 1'b0);
        end
        else
        begin
            target = $urandom_range(1, 12);
            for (int i = 0; i < target; i++)
                tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_bytes();
        bit calm;
        int gap;
        calm = 1'b0;
        foreach (tx_bytes[i])
        begin
            if ($urandom_range(0, 49) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte  <= tx_bytes[i];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            sb.note_rx_byte(tx_bytes[i]);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        bit calm;
        int gap;
        calm = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_readout(header_matched, temperature, supply_voltage, message_count);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int waited;
        sb       = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = '0;

        // directed: saturating temperature, CR before LF, then a garbage short line
        add_text("$TCHKD,99999,7,3*");
        tx_bytes.push_back(CH_CR);
        tx_bytes.push_back(CH_LF);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(CH_LF);
        add_text("$TCHKD,0,65535,1");
        tx_bytes.push_back(CH_LF);
        while (tx_bytes.size() < RX_TARGET)
            add_line();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_bytes();

        waited = 0;
        while (sb.pending_readouts.size() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending_readouts.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_readouts.size()));

        $display("Sent %0d bytes forming %0d finished lines, %0d of them with a good header.",
                 tx_bytes.size(), sb.lines_seen, sb.lines_matched);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
rtl/core/hsp_pkg.sv
rtl/core/hsp_digit_acc.sv
rtl/core/hsp_line_ctrl.sv
rtl/core/housekeeping_sentence_parser_top.sv
bench/tb_top.sv
